### hw/rtl/wtv_pkg.sv
// shared types and constants for the weighted tversky similarity block
`default_nettype none

package wtv_pkg;

   // default widths of the datapath
   localparam int KEY_BITS_DEFAULT    = 64;
   localparam int WEIGHT_BITS_DEFAULT = 32;
   localparam int SUM_BITS_DEFAULT    = 48;

   // configuration register file
   localparam int CFG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BETA  = 1'd1;
   localparam logic [CFG_BITS-1:0] ALPHA_RESET = 16'd2048;
   localparam logic [CFG_BITS-1:0] BETA_RESET  = 16'd2048;

   // result format: unsigned q1.16, one integer bit and sixteen fraction bits
   localparam int FRAC_BITS = 16;
   localparam int SIM_BITS  = FRAC_BITS + 1;
   localparam logic [SIM_BITS-1:0] SIM_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_DEN  = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      logic [SIM_BITS-1:0] similarity;
      status_type          status;
   } result_type;

   // ratio unit to top level
   typedef struct packed {
      logic       done;
      result_type result;
   } ratio_out_type;

endpackage

`default_nettype wire

### hw/rtl/wtv_req_if.sv
// entry channel: one sparse weighted entry per word
`default_nettype none

interface wtv_req_if #(
   parameter int KEY_BITS    = wtv_pkg::KEY_BITS_DEFAULT,
   parameter int WEIGHT_BITS = wtv_pkg::WEIGHT_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic [KEY_BITS-1:0]           entry_key;
   logic signed [WEIGHT_BITS-1:0] entry_weight;
   logic                          from_second;
   logic                          last_entry;

   modport source (output valid, entry_key, entry_weight, from_second, last_entry,
                   input ready);
   modport sink (input valid, entry_key, entry_weight, from_second, last_entry,
                 output ready);
endinterface

`default_nettype wire

### hw/rtl/wtv_rsp_if.sv
// result channel: one similarity word per set pair
`default_nettype none

interface wtv_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wtv_pkg::SIM_BITS-1:0]  similarity;
   logic [1:0]                    status;

   modport source (output valid, similarity, status, input ready);
   modport sink (input valid, similarity, status, output ready);
endinterface

`default_nettype wire

### hw/rtl/wtv_ratio.sv
// sequenced ratio unit: shared multiplier, shared adder, restoring divider
`default_nettype none

module wtv_ratio #(
   parameter int SUM_BITS = wtv_pkg::SUM_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SUM_BITS-1:0]    common_sum,
   input  logic signed [SUM_BITS-1:0]    first_only_sum,
   input  logic signed [SUM_BITS-1:0]    second_only_sum,
   input  logic                          saturated,
   input  logic [wtv_pkg::CFG_BITS-1:0]  alpha_weight,
   input  logic [wtv_pkg::CFG_BITS-1:0]  beta_weight,
   output wtv_pkg::ratio_out_type        ratio_out
);

   localparam int NUM_SHIFT = 12;
   localparam int PROD_BITS = SUM_BITS + wtv_pkg::CFG_BITS + 1;
   localparam int DEN_BITS  = PROD_BITS + 1;
   localparam int FRAC_BITS = wtv_pkg::FRAC_BITS;
   localparam int STEP_BITS = $clog2(FRAC_BITS);

   typedef enum logic [2:0] {
      R_IDLE,
      R_MUL_A,
      R_MUL_B,
      R_ADD_B,
      R_CHECK,
      R_DIV
   } rstate_type;

   rstate_type                  state_ff, state_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [DEN_BITS-1:0]  den_ff, den_in;
   logic [DEN_BITS-1:0]         rem_ff, rem_in;
   logic [FRAC_BITS-1:0]        quo_ff, quo_in;
   logic [STEP_BITS-1:0]        step_ff, step_in;
   logic                        done_ff, done_in;
   wtv_pkg::result_type         result_ff, result_in;

   logic signed [SUM_BITS-1:0]        mul_src;
   logic [wtv_pkg::CFG_BITS-1:0]      mul_k;
   logic signed [PROD_BITS-1:0]       src_ext, k_ext, prod_w;
   logic signed [DEN_BITS-1:0]        num_ext, prod_ext, add_base, den_sum;
   logic [DEN_BITS:0]                 rem_dbl;
   logic                              rem_ge;
   wtv_pkg::status_type               status_base;

   // shared multiplier: a-only mass first, then b-only mass
   assign mul_src = (state_ff == R_MUL_A) ? first_only_sum : second_only_sum;
   assign mul_k   = (state_ff == R_MUL_A) ? alpha_weight : beta_weight;
   assign src_ext = $signed({{(PROD_BITS-SUM_BITS){mul_src[SUM_BITS-1]}}, mul_src});
   assign k_ext   = $signed({{(PROD_BITS-wtv_pkg::CFG_BITS){1'b0}}, mul_k});
   assign prod_w  = src_ext * k_ext;

   // numerator in the q.28 scale of the weighted terms
   assign num_ext = $signed({{(DEN_BITS-SUM_BITS-NUM_SHIFT){common_sum[SUM_BITS-1]}},
                             common_sum, {NUM_SHIFT{1'b0}}});

   // shared adder for the denominator
   assign prod_ext = $signed({prod_ff[PROD_BITS-1], prod_ff});
   assign add_base = (state_ff == R_MUL_B) ? num_ext : den_ff;
   assign den_sum  = add_base + prod_ext;

   // one restoring division step
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_ge  = rem_dbl >= {1'b0, den_ff};

   assign status_base = saturated ? wtv_pkg::STATUS_SATURATED : wtv_pkg::STATUS_OK;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      prod_in   = prod_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      unique case (state_ff)
         R_IDLE: begin
            if (start) begin
               state_in = R_MUL_A;
            end
         end
         R_MUL_A: begin
            prod_in  = prod_w;
            state_in = R_MUL_B;
         end
         R_MUL_B: begin
            den_in   = den_sum;
            prod_in  = prod_w;
            state_in = R_ADD_B;
         end
         R_ADD_B: begin
            den_in   = den_sum;
            state_in = R_CHECK;
         end
         R_CHECK: begin
            if (den_ff[DEN_BITS-1] || (den_ff == '0)) begin
               // zero or negative denominator
               result_in.similarity = '0;
               result_in.status     = saturated ? wtv_pkg::STATUS_SATURATED
                                                : wtv_pkg::STATUS_ZERO_DEN;
               done_in  = 1'b1;
               state_in = R_IDLE;
            end else if ($unsigned(num_ext) >= $unsigned(den_ff)) begin
               // ratio at or above one
               result_in.similarity = wtv_pkg::SIM_ONE;
               result_in.status     = status_base;
               done_in  = 1'b1;
               state_in = R_IDLE;
            end else begin
               rem_in   = $unsigned(num_ext);
               quo_in   = '0;
               step_in  = STEP_BITS'(FRAC_BITS - 1);
               state_in = R_DIV;
            end
         end
         R_DIV: begin
            rem_in = rem_ge ? DEN_BITS'(rem_dbl - {1'b0, den_ff}) : rem_dbl[DEN_BITS-1:0];
            quo_in = {quo_ff[FRAC_BITS-2:0], rem_ge};
            if (step_ff == '0) begin
               result_in.similarity = {1'b0, quo_in};
               result_in.status     = status_base;
               done_in  = 1'b1;
               state_in = R_IDLE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prod_ff   <= prod_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      result_ff <= result_in;
   end

   assign ratio_out.done   = done_ff;
   assign ratio_out.result = result_ff;

endmodule

`default_nettype wire

### hw/rtl/weighted_tversky_similarity_top.sv
// weighted tversky similarity: entry pairing, saturating sums and result register
//
// Usage: the req channel carries a key-sorted merged stream of weighted entries
// from sets A and B; an entry is paired with the held one when keys match and
// sources differ. Each entry that is not marked last is taken without leaving
// S_IDLE, so such words stream back to back. The word marked last flushes the
// held entry and starts the ratio unit; req.ready stays low until the result
// is loaded into the result register. The rsp channel shows similarity
// (unsigned q1.16) and status. After the last word the ratio unit multiplies,
// adds and checks the denominator, then runs the restoring divider's 16 one-bit
// steps unless the denominator is not positive or the ratio is one or more;
// req.ready stays low throughout. The result register holds its word while
// rsp.ready is low and entries keep streaming meanwhile; the next set pair's
// result waits, with req.ready low, until that word is taken. The csr port
// writes alpha and beta. Synchronous reset clears the held entry, the sums,
// the saturation flag and the result valid and sets alpha and beta to 0.5.
`default_nettype none

module weighted_tversky_similarity_top #(
   parameter int KEY_BITS    = wtv_pkg::KEY_BITS_DEFAULT,
   parameter int WEIGHT_BITS = wtv_pkg::WEIGHT_BITS_DEFAULT,
   parameter int SUM_BITS    = wtv_pkg::SUM_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   wtv_req_if.sink                              req,
   wtv_rsp_if.source                            rsp,
   input  logic                                 csr_write_en,
   input  logic [wtv_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wtv_pkg::CFG_BITS-1:0]         csr_wdata
);

   localparam int WX_BITS  = WEIGHT_BITS + 1;
   localparam int EXT_BITS = ((SUM_BITS > WX_BITS) ? SUM_BITS : WX_BITS) + 1;
   localparam logic [SUM_BITS-1:0] SMAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic [SUM_BITS-1:0] SMIN = {1'b1, {(SUM_BITS-1){1'b0}}};
   localparam logic signed [EXT_BITS-1:0] SMAX_EXT = {{(EXT_BITS-SUM_BITS){1'b0}}, SMAX};
   localparam logic signed [EXT_BITS-1:0] SMIN_EXT = {{(EXT_BITS-SUM_BITS){1'b1}}, SMIN};

   typedef enum logic [1:0] {
      S_IDLE,
      S_FLUSH,
      S_RATIO,
      S_OUT
   } state_type;

   // saturating add, flag in the top bit
   function automatic logic [SUM_BITS:0] sat_add(input logic signed [SUM_BITS-1:0] sum,
                                                 input logic signed [WX_BITS-1:0] w);
      logic signed [EXT_BITS-1:0] total;
      total = $signed({{(EXT_BITS-SUM_BITS){sum[SUM_BITS-1]}}, sum})
            + $signed({{(EXT_BITS-WX_BITS){w[WX_BITS-1]}}, w});
      if (total > SMAX_EXT) begin
         sat_add = {1'b1, SMAX};
      end else if (total < SMIN_EXT) begin
         sat_add = {1'b1, SMIN};
      end else begin
         sat_add = {1'b0, total[SUM_BITS-1:0]};
      end
   endfunction

   state_type                       state_ff, state_in;
   logic [wtv_pkg::CFG_BITS-1:0]    alpha_ff, beta_ff;
   logic                            held_valid_ff, held_valid_in;
   logic [KEY_BITS-1:0]             held_key_ff, held_key_in;
   logic signed [WEIGHT_BITS-1:0]   held_weight_ff, held_weight_in;
   logic                            held_second_ff, held_second_in;
   logic signed [SUM_BITS-1:0]      common_ff, common_in;
   logic signed [SUM_BITS-1:0]      first_ff, first_in;
   logic signed [SUM_BITS-1:0]      second_ff, second_in;
   logic                            sat_ff, sat_in;
   wtv_pkg::result_type             rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic                            match;
   logic signed [WX_BITS-1:0]       new_x, held_x, wa, wb, min_w, exc_a, exc_b;
   logic                            a_lt_b;
   logic                            add_c_en, add_f_en, add_s_en;
   logic signed [WX_BITS-1:0]       add_c, add_f, add_s;
   logic [SUM_BITS:0]               sat_c, sat_f, sat_s;
   logic                            ratio_start, clear_run;
   wtv_pkg::ratio_out_type          ratio_out;

   // pairing of the incoming word with the held entry
   assign new_x  = $signed({req.entry_weight[WEIGHT_BITS-1], req.entry_weight});
   assign held_x = $signed({held_weight_ff[WEIGHT_BITS-1], held_weight_ff});
   assign match  = held_valid_ff && (held_key_ff == req.entry_key)
                && (held_second_ff != req.from_second);
   assign wa     = req.from_second ? held_x : new_x;
   assign wb     = req.from_second ? new_x : held_x;
   assign a_lt_b = wa < wb;
   assign min_w  = a_lt_b ? wa : wb;
   assign exc_a  = a_lt_b ? '0 : (wa - wb);
   assign exc_b  = a_lt_b ? (wb - wa) : '0;

   // sequencer and addend selection
   always_comb begin
      state_in       = state_ff;
      held_valid_in  = held_valid_ff;
      held_key_in    = held_key_ff;
      held_weight_in = held_weight_ff;
      held_second_in = held_second_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp.ready;
      add_c_en       = 1'b0;
      add_f_en       = 1'b0;
      add_s_en       = 1'b0;
      add_c          = '0;
      add_f          = '0;
      add_s          = '0;
      ratio_start    = 1'b0;
      clear_run      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               if (match) begin
                  held_valid_in = 1'b0;
                  // a pair with a negative weight adds nothing
                  if (!wa[WX_BITS-1] && !wb[WX_BITS-1]) begin
                     add_c_en = 1'b1;
                     add_c    = min_w;
                     add_f_en = alpha_ff != '0;
                     add_f    = exc_a;
                     add_s_en = beta_ff != '0;
                     add_s    = exc_b;
                  end
               end else begin
                  if (held_valid_ff) begin
                     if (held_second_ff) begin
                        add_s_en = beta_ff != '0;
                        add_s    = held_x;
                     end else begin
                        add_f_en = alpha_ff != '0;
                        add_f    = held_x;
                     end
                  end
                  held_valid_in  = 1'b1;
                  held_key_in    = req.entry_key;
                  held_weight_in = req.entry_weight;
                  held_second_in = req.from_second;
               end
               if (req.last_entry) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            // count a leftover held entry as unmatched
            if (held_valid_ff) begin
               if (held_second_ff) begin
                  add_s_en = beta_ff != '0;
                  add_s    = held_x;
               end else begin
                  add_f_en = alpha_ff != '0;
                  add_f    = held_x;
               end
            end
            held_valid_in = 1'b0;
            ratio_start   = 1'b1;
            state_in      = S_RATIO;
         end
         S_RATIO: begin
            if (ratio_out.done) begin
               clear_run = 1'b1;
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_in       = ratio_out.result;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            // result register busy: load once its word is taken
            if (rsp.ready) begin
               rsp_in       = ratio_out.result;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // saturating accumulators
   assign sat_c = sat_add(common_ff, add_c);
   assign sat_f = sat_add(first_ff, add_f);
   assign sat_s = sat_add(second_ff, add_s);

   always_comb begin
      if (clear_run) begin
         common_in = '0;
         first_in  = '0;
         second_in = '0;
         sat_in    = 1'b0;
      end else begin
         common_in = add_c_en ? $signed(sat_c[SUM_BITS-1:0]) : common_ff;
         first_in  = add_f_en ? $signed(sat_f[SUM_BITS-1:0]) : first_ff;
         second_in = add_s_en ? $signed(sat_s[SUM_BITS-1:0]) : second_ff;
         sat_in    = sat_ff | (add_c_en & sat_c[SUM_BITS])
                   | (add_f_en & sat_f[SUM_BITS]) | (add_s_en & sat_s[SUM_BITS]);
      end
   end

   // state, sums, held entry, result word and config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_valid_ff <= 1'b0;
         common_ff     <= '0;
         first_ff      <= '0;
         second_ff     <= '0;
         sat_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         alpha_ff      <= wtv_pkg::ALPHA_RESET;
         beta_ff       <= wtv_pkg::BETA_RESET;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
         common_ff     <= common_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         sat_ff        <= sat_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               wtv_pkg::CSR_ALPHA: alpha_ff <= csr_wdata;
               wtv_pkg::CSR_BETA:  beta_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      held_key_ff    <= held_key_in;
      held_weight_ff <= held_weight_in;
      held_second_ff <= held_second_in;
      rsp_ff         <= rsp_in;
   end

   wtv_ratio #(
      .SUM_BITS (SUM_BITS)
   ) u_ratio (
      .clock           (clock),
      .reset           (reset),
      .start           (ratio_start),
      .common_sum      (common_ff),
      .first_only_sum  (first_ff),
      .second_only_sum (second_ff),
      .saturated       (sat_ff),
      .alpha_weight    (alpha_ff),
      .beta_weight     (beta_ff),
      .ratio_out       (ratio_out)
   );

   // channel outputs
   assign req.ready      = state_ff == S_IDLE;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.similarity = rsp_ff.similarity;
   assign rsp.status     = rsp_ff.status;

endmodule

`default_nettype wire

### verif/tb_weighted_tversky_similarity_top.sv
// testbench for weighted_tversky_similarity_top: streams set pairs and checks each score word
module tb_weighted_tversky_similarity_top;

   localparam longint SUM_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_MIN      = -SUM_MAX - 1;
   localparam int     IDLE_LIMIT   = 2000;
   localparam int     DRAIN_CYCLES = 30;
   localparam int     LONG_HOLD    = 300;
   localparam int     RANDOM_ITEMS = 1550;
   localparam logic signed [31:0] W_ONE = 32'sh0001_0000;
   localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] W_MIN = 32'sh8000_0000;

   logic                               clock;
   logic                               reset;
   logic                               csr_write_en;
   logic [wtv_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [wtv_pkg::CFG_BITS-1:0]       csr_wdata;

   wtv_req_if req_ch ();
   wtv_rsp_if rsp_ch ();

   weighted_tversky_similarity_top dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // scoring state mirrored from the block
   logic [wtv_pkg::CFG_BITS-1:0] alpha_q;
   logic [wtv_pkg::CFG_BITS-1:0] beta_q;
   bit                           hold_valid;
   bit                           hold_second;
   logic [63:0]                  hold_key;
   longint                       hold_weight;
   longint                       sum_common;
   longint                       sum_a_only;
   longint                       sum_b_only;
   bit                           sum_clamped;

   wtv_pkg::result_type pending_scores[$];
   int                  errors;
   int                  idle_cycles;
   int                  entries_sent;
   int                  hold_request;
   bit                  src_gaps;
   bit                  sink_gaps;

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_sums();
      hold_valid  = 0;
      hold_second = 0;
      hold_key    = '0;
      hold_weight = 0;
      sum_common  = 0;
      sum_a_only  = 0;
      sum_b_only  = 0;
      sum_clamped = 0;
   endfunction

   // saturating add into a signed 48-bit sum
   function automatic longint clamp_add(input longint acc, input longint w);
      longint t;
      t = acc + w;
      if (t > SUM_MAX) begin
         sum_clamped = 1;
         return SUM_MAX;
      end
      if (t < SUM_MIN) begin
         sum_clamped = 1;
         return SUM_MIN;
      end
      return t;
   endfunction

   function automatic void count_unmatched(input bit second, input longint w);
      if (second) begin
         if (beta_q != 0) sum_b_only = clamp_add(sum_b_only, w);
      end else if (alpha_q != 0) begin
         sum_a_only = clamp_add(sum_a_only, w);
      end
   endfunction

   // matched pair: min to common, excess to its own side; negative weights drop the pair
   function automatic void count_pair(input longint wa, input longint wb);
      if (wa >= 0 && wb >= 0) begin
         sum_common = clamp_add(sum_common, (wa < wb) ? wa : wb);
         if (alpha_q != 0 && wa > wb) sum_a_only = clamp_add(sum_a_only, wa - wb);
         if (beta_q != 0 && wb > wa) sum_b_only = clamp_add(sum_b_only, wb - wa);
      end
   endfunction

   // common / (alpha*a + beta*b + common) in q1.16, rounded down
   function automatic wtv_pkg::result_type tversky_score();
      logic signed [127:0] num;
      logic signed [127:0] den;
      logic signed [127:0] a_term;
      logic signed [127:0] b_term;
      logic signed [127:0] k;
      logic [127:0]        quot;
      wtv_pkg::result_type r;
      num    = 128'(sum_common);
      num    = num <<< 12;
      a_term = 128'(sum_a_only);
      k      = {112'd0, alpha_q};
      a_term = a_term * k;
      b_term = 128'(sum_b_only);
      k      = {112'd0, beta_q};
      b_term = b_term * k;
      den    = a_term + b_term + num;
      r.status = sum_clamped ? wtv_pkg::STATUS_SATURATED : wtv_pkg::STATUS_OK;
      if (den <= 0) begin
         if (!sum_clamped) r.status = wtv_pkg::STATUS_ZERO_DEN;
         r.similarity = '0;
      end else if ($unsigned(num) >= $unsigned(den)) begin
         r.similarity = wtv_pkg::SIM_ONE;
      end else begin
         quot = ($unsigned(num) << 16) / $unsigned(den);
         r.similarity = quot[wtv_pkg::SIM_BITS-1:0];
      end
      return r;
   endfunction

   // one accepted entry word through the pairing logic
   function automatic void take_entry(input logic [63:0] key, input logic signed [31:0] wt,
                                      input bit second, input bit last);
      longint w;
      w = longint'(wt);
      if (hold_valid && hold_key == key && hold_second != second) begin
         if (second) count_pair(hold_weight, w);
         else count_pair(w, hold_weight);
         hold_valid = 0;
      end else begin
         if (hold_valid) count_unmatched(hold_second, hold_weight);
         hold_valid  = 1;
         hold_key    = key;
         hold_weight = w;
         hold_second = second;
      end
      if (last) begin
         if (hold_valid) count_unmatched(hold_second, hold_weight);
         hold_valid = 0;
         pending_scores.insert(pending_scores.size(), tversky_score());
         clear_sums();
      end
   endfunction

   // monitor both channels and count idle cycles
   always @(posedge clock) begin : score_monitor
      wtv_pkg::result_type want;
      bit                  moved;
      moved = 0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            take_entry(req_ch.entry_key, req_ch.entry_weight, req_ch.from_second,
                       req_ch.last_entry);
            moved = 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1;
            if (pending_scores.size() == 0) begin
               $display("%0t: unexpected score word similarity %0d status %0d", $time,
                        rsp_ch.similarity, rsp_ch.status);
               errors++;
            end else begin
               want = pending_scores.pop_front();
               if (rsp_ch.similarity !== want.similarity) begin
                  $display("%0t: similarity expected %0d actual %0d", $time,
                           want.similarity, rsp_ch.similarity);
                  errors++;
               end
               if (rsp_ch.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_ch.status);
                  errors++;
               end
            end
         end
         if (moved) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   // watchdog
   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_weighted_tversky_similarity_top: errors");
      $finish;
   end

   // result side ready: random stall bursts plus the long hold-off
   initial begin
      int burst;
      burst = 0;
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_ch.ready = 0;
            hold_request--;
         end else if (burst > 0) begin
            rsp_ch.ready = 0;
            burst--;
         end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready = 0;
            burst = $urandom_range(0, 4);
         end else begin
            rsp_ch.ready = 1;
         end
      end
   end

   // offer one entry word, called and returning at a falling edge
   task automatic send_entry(input logic [63:0] key, input logic signed [31:0] wt,
                             input bit second, input bit last);
      if (src_gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_ch.valid        = 1;
      req_ch.entry_key    = key;
      req_ch.entry_weight = wt;
      req_ch.from_second  = second;
      req_ch.last_entry   = last;
      do @(posedge clock); while (!req_ch.ready);
      entries_sent++;
      @(negedge clock);
   endtask

   // drop valid and wait until the block has gone quiet
   task automatic settle();
      req_ch.valid = 0;
      while (pending_scores.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [wtv_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [wtv_pkg::CFG_BITS-1:0] value);
      csr_write_en = 1;
      csr_index    = index;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 0;
      if (index == wtv_pkg::CSR_ALPHA) alpha_q = value;
      else if (index == wtv_pkg::CSR_BETA) beta_q = value;
   endtask

   function automatic logic signed [31:0] pick_weight();
      case ($urandom_range(0, 15))
         0:       return W_MAX;
         1:       return W_MIN;
         2:       return 0;
         3:       return ~$urandom_range(0, 65535);
         4:       return $urandom;
         default: return $urandom_range(1, 32'h00FF_FFFF);
      endcase
   endfunction

   // one merged stream of n_keys key slots, last word closes the set pair
   task automatic send_set_pair(input int n_keys);
      logic [63:0] key;
      bit          src;
      bit          fin;
      int          i;
      key = {$urandom, $urandom};
      for (i = 0; i < n_keys; i++) begin
         fin = (i == n_keys - 1);
         src = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               send_entry(key, pick_weight(), src, 0);
               send_entry(key, pick_weight(), !src, fin);
            end
            4, 5, 6: send_entry(key, pick_weight(), src, fin);
            // same key twice from one side
            7: begin
               send_entry(key, pick_weight(), src, 0);
               send_entry(key, pick_weight(), src, fin);
            end
            // near miss on the key
            8: begin
               send_entry(key, pick_weight(), src, 0);
               send_entry(key + 1, pick_weight(), !src, fin);
            end
            // pair followed by a leftover with the same key
            default: begin
               send_entry(key, pick_weight(), src, 0);
               send_entry(key, pick_weight(), !src, 0);
               send_entry(key, pick_weight(), src, fin);
            end
         endcase
         key = key + $urandom_range(2, 1000);
      end
   endtask

   task automatic run_setting(input logic [wtv_pkg::CFG_BITS-1:0] a,
                              input logic [wtv_pkg::CFG_BITS-1:0] b, input int pairs);
      settle();
      write_csr(wtv_pkg::CSR_ALPHA, a);
      write_csr(wtv_pkg::CSR_BETA, b);
      repeat (pairs) send_set_pair($urandom_range(1, 6));
   endtask

   // hand-picked set pairs at the reset weights
   task automatic test_directed();
      src_gaps  = 0;
      sink_gaps = 0;
      // lone a entry: nothing common
      send_entry(64'd0, W_ONE, 0, 1);
      // equal pair on the all-ones key scores one
      send_entry('1, W_ONE, 0, 0);
      send_entry('1, W_ONE, 1, 1);
      // a heavier than b
      send_entry(64'h5555_5555_5555_5555, 3 * W_ONE, 0, 0);
      send_entry(64'h5555_5555_5555_5555, W_ONE, 1, 1);
      // negative weight drops the pair, zero denominator
      send_entry(64'hAAAA_AAAA_AAAA_AAAA, -W_ONE, 0, 0);
      send_entry(64'hAAAA_AAAA_AAAA_AAAA, 2 * W_ONE, 1, 1);
      // negative unmatched mass pushes the ratio past one
      send_entry(64'd10, -(W_ONE / 2), 0, 0);
      send_entry(64'd11, W_ONE, 0, 0);
      send_entry(64'd11, W_ONE, 1, 1);
      // same key from the same side is not a pair
      send_entry(64'd20, W_ONE, 0, 0);
      send_entry(64'd20, 2 * W_ONE, 0, 0);
      send_entry(64'd20, 2 * W_ONE, 1, 1);
      // weight extremes
      send_entry(64'h8000_0000_0000_0000, W_MAX, 0, 0);
      send_entry(64'h8000_0000_0000_0000, W_MIN, 1, 0);
      send_entry(64'h8000_0000_0000_0001, 0, 0, 0);
      send_entry(64'h8000_0000_0000_0002, -1, 1, 1);
      // zero weight alone
      send_entry(64'd30, 0, 0, 1);
      // b before a on one key
      send_entry(64'd40, W_ONE, 1, 0);
      send_entry(64'd40, W_ONE / 2, 0, 1);
      settle();
   endtask

   // alpha and beta at the corners, zeros included
   task automatic test_config_sweep();
      src_gaps  = 1;
      sink_gaps = 1;
      run_setting(16'd0, 16'd2048, 4);
      run_setting(16'd2048, 16'd0, 4);
      run_setting(16'd0, 16'd0, 4);
      run_setting(16'hFFFF, 16'hFFFF, 4);
      run_setting(16'd1, 16'hFFFF, 4);
      run_setting(16'hFFFF, 16'd1, 4);
      run_setting(16'd4096, 16'd4096, 4);
      run_setting(16'($urandom), 16'($urandom), 4);
      settle();
   endtask

   // result side holds off while more entries keep coming
   task automatic test_backpressure();
      src_gaps     = 0;
      sink_gaps    = 1;
      hold_request = LONG_HOLD;
      repeat (4) send_set_pair($urandom_range(1, 3));
      settle();
   endtask

   // random set pairs, occasional reprogramming, quiet tail
   task automatic test_random();
      int start;
      start     = entries_sent;
      src_gaps  = 1;
      sink_gaps = 1;
      while (entries_sent - start < RANDOM_ITEMS) begin
         if (entries_sent - start >= RANDOM_ITEMS - 300) begin
            src_gaps  = 0;
            sink_gaps = 0;
         end
         if ($urandom_range(0, 39) == 0) run_setting(16'($urandom), 16'($urandom), 0);
         send_set_pair(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                    : $urandom_range(1, 6));
      end
   endtask

   initial begin
      req_ch.valid        = 0;
      req_ch.entry_key    = '0;
      req_ch.entry_weight = '0;
      req_ch.from_second  = 0;
      req_ch.last_entry   = 0;
      csr_write_en        = 0;
      csr_index           = wtv_pkg::CSR_ALPHA;
      csr_wdata           = '0;
      reset               = 1;
      errors              = 0;
      idle_cycles         = 0;
      entries_sent        = 0;
      hold_request        = 0;
      src_gaps            = 0;
      sink_gaps           = 0;
      alpha_q             = wtv_pkg::ALPHA_RESET;
      beta_q              = wtv_pkg::BETA_RESET;
      clear_sums();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_directed();
      test_config_sweep();
      test_backpressure();
      test_random();
      settle();

      if (errors == 0 && pending_scores.size() == 0) begin
         $display("tb_weighted_tversky_similarity_top: clean");
      end else begin
         $display("tb_weighted_tversky_similarity_top: errors");
      end
      $finish;
   end

endmodule
